// ===== rtl/ptd_pkg.sv =====
// Shared types and constants of the periodic task dispatcher.
`default_nettype none
package ptd_pkg;
   localparam int unsigned MaxTasksDefault = 16;
   localparam int unsigned TopLevelDefault = 7;
   localparam logic [15:0] NoId = 16'hFFFF;

   typedef enum logic [2:0] {
      ACT_TICK = 3'd0, ACT_CREATE = 3'd1, ACT_DELETE = 3'd2, ACT_STATE = 3'd3,
      ACT_PERIOD = 3'd4, ACT_DELAY = 3'd5, ACT_PRIO = 3'd6, ACT_NONE = 3'd7
   } action_type;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNotFound = 2'd1;
   localparam logic [1:0] StatusFull = 2'd2;

   localparam logic [1:0] ModeDisable = 2'd0;
   localparam logic [1:0] ModeToggle = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIND, ST_TICK, ST_IDSCAN, ST_POS, ST_SHIFT_UP, ST_INSERT,
      ST_SHIFT_DN, ST_UPDATE, ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch request, clear scan index
      logic scan_step;   // advance scan index
      logic scan_clear;  // restart scan index at 0
      logic fire;        // dispatch entry at scan index
      logic bump_cand;   // candidate id + 1, restart scan
      logic pos_step;    // position scan step
      logic shift_up;    // move entry idx-1 to idx, idx--
      logic insert;      // write stashed entry at pos, count++
      logic shift_dn;    // move entry idx+1 to idx, idx++
      logic remove_done; // count--, fix next free id
      logic update;      // state, period, delay update at slot
      logic set_full;
      logic set_notfound;
      logic load_idx_top;// idx = count (for shift up)
      logic stash;       // copy found entry to stash
      logic set_created; // new id result
   } ptd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;    // idx >= count
      logic match;       // entry at idx matches request id
      logic due;         // entry at idx enabled and due
      logic cand_hit;    // entry at idx holds the candidate id
      logic full;        // table full
      logic at_pos;      // shift up reached insert position
      logic last_dn;     // idx + 1 >= count
      action_type action;
   } ptd_sts_type;
endpackage
`default_nettype wire

// ===== rtl/ptd_ctrl.sv =====
// Sequencer of the periodic task dispatcher.
`default_nettype none
module ptd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire ptd_pkg::ptd_sts_type sts,
   output ptd_pkg::ptd_cmd_type cmd
);
   import ptd_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            case (sts.action)
               ACT_TICK: state_in = ST_TICK;
               ACT_CREATE: begin
                  if (sts.full) begin
                     cmd.set_full = 1'b1;
                     state_in = ST_RESP;
                  end else state_in = ST_IDSCAN;
               end
               ACT_NONE: state_in = ST_RESP;
               default: begin
                  if (sts.scan_end) begin
                     cmd.set_notfound = 1'b1;
                     state_in = ST_RESP;
                  end else if (sts.match) begin
                     cmd.stash = 1'b1;
                     if (sts.action == ACT_DELETE || sts.action == ACT_PRIO)
                        state_in = ST_SHIFT_DN;
                     else state_in = ST_UPDATE;
                  end else cmd.scan_step = 1'b1;
               end
            endcase
         end
         ST_TICK: begin
            if (sts.scan_end) state_in = ST_RESP;
            else if (sts.due) begin
               cmd.fire = 1'b1;
               state_in = ST_RESP;
            end else cmd.scan_step = 1'b1;
         end
         ST_IDSCAN: begin
            if (sts.scan_end) begin
               cmd.set_created = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = ST_POS;
            end else if (sts.cand_hit) cmd.bump_cand = 1'b1;
            else cmd.scan_step = 1'b1;
         end
         ST_POS: begin
            if (sts.scan_end) begin
               cmd.load_idx_top = 1'b1;
               state_in = ST_SHIFT_UP;
            end else cmd.pos_step = 1'b1;
         end
         ST_SHIFT_UP: begin
            if (sts.at_pos) begin
               cmd.insert = 1'b1;
               state_in = ST_RESP;
            end else cmd.shift_up = 1'b1;
         end
         ST_SHIFT_DN: begin
            if (sts.last_dn) begin
               cmd.remove_done = 1'b1;
               if (sts.action == ACT_PRIO) begin
                  cmd.scan_clear = 1'b1;
                  state_in = ST_POS;
               end else state_in = ST_RESP;
            end else cmd.shift_dn = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.insert, cmd.remove_done, cmd.update, cmd.fire}))
      else $error("conflicting table commands");
`endif
endmodule
`default_nettype wire

// ===== rtl/ptd_dpath.sv =====
// Task table and arithmetic of the periodic task dispatcher.
`default_nettype none
module ptd_dpath #(
   parameter int unsigned MAX_TASKS = ptd_pkg::MaxTasksDefault,
   parameter int unsigned TOP_LEVEL = ptd_pkg::TopLevelDefault,
   localparam int unsigned IW = $clog2(MAX_TASKS),
   localparam int unsigned CW = $clog2(MAX_TASKS + 1),
   localparam int unsigned LW = $clog2(TOP_LEVEL + 1)
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ptd_pkg::ptd_cmd_type cmd,
   output ptd_pkg::ptd_sts_type sts,
   input  wire logic [31:0] comp_range,
   input  wire logic [2:0] req_action,
   input  wire logic [31:0] req_now,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0] req_priority_req,
   input  wire logic [31:0] req_period,
   input  wire logic [1:0] req_enable_mode,
   input  wire logic [31:0] req_delay_ticks,
   input  wire logic req_from_now,
   output logic rsp_fired,
   output logic [15:0] rsp_fired_id,
   output logic [31:0] rsp_latency,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_new_id,
   output logic [CW-1:0] rsp_task_count
);
   import ptd_pkg::*;

   logic [15:0] id_ff [MAX_TASKS];
   logic [31:0] per_ff [MAX_TASKS];
   logic [31:0] lr_ff [MAX_TASKS];
   logic en_ff [MAX_TASKS];
   logic [LW-1:0] lvl_ff [MAX_TASKS];

   logic [CW-1:0] count_ff;
   logic [15:0] nfree_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] pos_ff;
   logic [15:0] cand_ff;
   action_type act_ff;
   logic [31:0] now_ff, per_req_ff, dly_ff;
   logic [15:0] tid_ff;
   logic [LW-1:0] lvlreq_ff;
   logic [1:0] mode_ff;
   logic fromnow_ff;
   // stash of the entry being inserted
   logic [15:0] s_id_ff;
   logic [31:0] s_per_ff, s_lr_ff;
   logic s_en_ff;

   logic fired_ff;
   logic [15:0] fid_ff, newid_ff;
   logic [31:0] lat_ff;
   logic [1:0] status_ff;

   logic [IW-1:0] ix, ixm1, ixp1, px;
   logic [31:0] due;
   logic [LW-1:0] clamp;
   logic [15:0] cand_wrap;
   logic en_new;

   assign ix = idx_ff[IW-1:0];
   assign ixm1 = IW'(idx_ff - 1'b1);
   assign ixp1 = IW'(idx_ff + 1'b1);
   assign px = pos_ff[IW-1:0];
   assign due = lr_ff[ix] + per_ff[ix];
   assign clamp = (req_priority_req > 8'(TOP_LEVEL)) ? LW'(TOP_LEVEL)
                                                      : LW'(req_priority_req);
   assign cand_wrap = (cand_ff == NoId) ? 16'd0 : cand_ff;
   assign en_new = (mode_ff == ModeToggle) ? !en_ff[ix] : (mode_ff != ModeDisable);

   always_comb begin
      sts.scan_end = (idx_ff >= count_ff);
      sts.match = (id_ff[ix] == tid_ff);
      sts.due = en_ff[ix] && (now_ff >= due);
      sts.cand_hit = (id_ff[ix] == cand_wrap);
      sts.full = (count_ff >= CW'(MAX_TASKS));
      sts.at_pos = (idx_ff == pos_ff);
      sts.last_dn = ({1'b0, idx_ff} + 1'b1 >= {1'b0, count_ff});
      sts.action = act_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nfree_ff <= '0;
      end else begin
         if (cmd.insert) count_ff <= count_ff + 1'b1;
         if (cmd.remove_done) begin
            count_ff <= count_ff - 1'b1;
            if (nfree_ff == s_id_ff + 16'd1) nfree_ff <= s_id_ff;
         end
         if (cmd.set_created) nfree_ff <= cand_wrap + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action_type'(req_action);
         now_ff <= req_now;
         tid_ff <= req_task_id;
         lvlreq_ff <= clamp;
         per_req_ff <= (req_period == 32'd0) ? 32'd1 : req_period;
         mode_ff <= req_enable_mode;
         dly_ff <= req_delay_ticks;
         fromnow_ff <= req_from_now;
         idx_ff <= '0;
         pos_ff <= '0;
         cand_ff <= nfree_ff;
         fired_ff <= 1'b0;
         fid_ff <= '0;
         lat_ff <= '0;
         status_ff <= StatusOk;
         newid_ff <= NoId;
      end
      if (cmd.scan_step) idx_ff <= idx_ff + 1'b1;
      if (cmd.scan_clear) idx_ff <= '0;
      if (cmd.bump_cand) begin
         cand_ff <= cand_wrap + 16'd1;
         idx_ff <= '0;
      end
      if (cmd.set_created) begin
         newid_ff <= cand_wrap;
         s_id_ff <= cand_wrap;
         s_per_ff <= per_req_ff;
         s_lr_ff <= now_ff - per_req_ff;
         s_en_ff <= (mode_ff != ModeDisable);
      end
      if (cmd.pos_step) begin
         if (lvl_ff[ix] <= lvlreq_ff) pos_ff <= idx_ff + 1'b1;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.load_idx_top) idx_ff <= count_ff;
      if (cmd.shift_up) begin
         id_ff[ix] <= id_ff[ixm1];
         per_ff[ix] <= per_ff[ixm1];
         lr_ff[ix] <= lr_ff[ixm1];
         en_ff[ix] <= en_ff[ixm1];
         lvl_ff[ix] <= lvl_ff[ixm1];
         idx_ff <= idx_ff - 1'b1;
      end
      if (cmd.insert) begin
         id_ff[px] <= s_id_ff;
         per_ff[px] <= s_per_ff;
         lr_ff[px] <= s_lr_ff;
         en_ff[px] <= s_en_ff;
         lvl_ff[px] <= lvlreq_ff;
      end
      if (cmd.stash) begin
         s_id_ff <= id_ff[ix];
         s_per_ff <= per_ff[ix];
         s_lr_ff <= lr_ff[ix];
         s_en_ff <= en_ff[ix];
      end
      if (cmd.shift_dn) begin
         id_ff[ix] <= id_ff[ixp1];
         per_ff[ix] <= per_ff[ixp1];
         lr_ff[ix] <= lr_ff[ixp1];
         en_ff[ix] <= en_ff[ixp1];
         lvl_ff[ix] <= lvl_ff[ixp1];
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.update) begin
         case (act_ff)
            ACT_STATE: begin
               en_ff[ix] <= en_new;
               if (en_new) lr_ff[ix] <= now_ff - per_ff[ix];
            end
            ACT_PERIOD: begin
               per_ff[ix] <= per_req_ff;
               lr_ff[ix] <= now_ff - per_req_ff;
            end
            ACT_DELAY: lr_ff[ix] <= fromnow_ff ? now_ff + dly_ff : lr_ff[ix] + dly_ff;
            default: ;
         endcase
      end
      if (cmd.fire) begin
         fired_ff <= 1'b1;
         fid_ff <= id_ff[ix];
         lat_ff <= now_ff - due;
         lr_ff[ix] <= (now_ff - due <= comp_range) ? due : now_ff;
      end
      if (cmd.set_full) status_ff <= StatusFull;
      if (cmd.set_notfound) status_ff <= StatusNotFound;
   end

   assign rsp_fired = fired_ff;
   assign rsp_fired_id = fid_ff;
   assign rsp_latency = lat_ff;
   assign rsp_status = status_ff;
   assign rsp_new_id = newid_ff;
   assign rsp_task_count = count_ff;

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS)) else $error("task count overflow");
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> count_ff < CW'(MAX_TASKS)) else $error("insert into full table");
   a_fire_late: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> rsp_fired) else $error("fire not recorded");
`endif
endmodule
`default_nettype wire

// ===== rtl/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher.
`default_nettype none
// Keeps up to MAX_TASKS periodic tasks ordered by priority level (0 first,
// insertion order within a level). One request beat carries an action: tick
// dispatches the first enabled due task and reports its id and lateness;
// the others create, delete, enable/disable/toggle, re-period, delay or
// re-prioritise a task. Every request gives exactly one response beat.
// Requests are handled one at a time by a sequencer that walks the table one
// entry per cycle. A tick walks until the first due task; a create walks the
// table for a free id, then for the insert position, then shifts entries up;
// a delete shifts the entries behind it down; a re-prioritise does a delete,
// then the create's position walk and shift. csr_wr_en writes comp_range,
// the largest lateness that still advances a task by exactly one period.
// Table slots need no clearing; only slots below the task count are read.
module periodic_task_dispatcher #(
   parameter int unsigned MAX_TASKS = ptd_pkg::MaxTasksDefault,
   parameter int unsigned TOP_LEVEL = ptd_pkg::TopLevelDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [2:0] req_action,
   input  wire logic [31:0] req_now,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0] req_priority_req,
   input  wire logic [31:0] req_period,
   input  wire logic [1:0] req_enable_mode,
   input  wire logic [31:0] req_delay_ticks,
   input  wire logic req_from_now,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_fired,
   output logic [15:0] rsp_fired_id,
   output logic [31:0] rsp_latency,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_new_id,
   output logic [4:0] rsp_task_count
);
   import ptd_pkg::*;
   localparam int unsigned CW = $clog2(MAX_TASKS + 1);

   logic [31:0] comp_range_ff;
   ptd_cmd_type cmd;
   ptd_sts_type sts;
   logic [CW-1:0] count;

   // compensation range register
   always_ff @(posedge clock) begin
      if (reset) comp_range_ff <= '0;
      else if (csr_wr_en) comp_range_ff <= csr_wr_data;
   end

   ptd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   ptd_dpath #(.MAX_TASKS(MAX_TASKS), .TOP_LEVEL(TOP_LEVEL)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .comp_range(comp_range_ff),
      .req_action(req_action), .req_now(req_now), .req_task_id(req_task_id),
      .req_priority_req(req_priority_req), .req_period(req_period),
      .req_enable_mode(req_enable_mode), .req_delay_ticks(req_delay_ticks),
      .req_from_now(req_from_now),
      .rsp_fired(rsp_fired), .rsp_fired_id(rsp_fired_id),
      .rsp_latency(rsp_latency), .rsp_status(rsp_status),
      .rsp_new_id(rsp_new_id), .rsp_task_count(count)
   );

   // count width follows MAX_TASKS; the port is fixed at five bits
   assign rsp_task_count = 5'(count);
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the periodic task dispatcher.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptd_pkg::*;

   localparam int unsigned Slots = 16;
   localparam int unsigned TopLvl = 7;

   // one request beat
   typedef struct {
      action_type act;
      logic [31:0] now;
      logic [15:0] task_id;
      logic [7:0] prio;
      logic [31:0] period;
      logic [1:0] mode;
      logic [31:0] dly;
      logic from_now;
   } req_beat_t;

   // one response beat
   typedef struct {
      logic fired;
      logic [15:0] fired_id;
      logic [31:0] latency;
      logic [1:0] status;
      logic [15:0] new_id;
      logic [4:0] task_count;
   } rsp_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [31:0] req_now = '0;
   logic [15:0] req_task_id = '0;
   logic [7:0] req_priority_req = '0;
   logic [31:0] req_period = '0;
   logic [1:0] req_enable_mode = '0;
   logic [31:0] req_delay_ticks = '0;
   logic req_from_now = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_fired;
   logic [15:0] rsp_fired_id;
   logic [31:0] rsp_latency;
   logic [1:0] rsp_status;
   logic [15:0] rsp_new_id;
   logic [4:0] rsp_task_count;

   periodic_task_dispatcher dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_now(req_now), .req_task_id(req_task_id),
      .req_priority_req(req_priority_req), .req_period(req_period),
      .req_enable_mode(req_enable_mode), .req_delay_ticks(req_delay_ticks),
      .req_from_now(req_from_now),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_fired(rsp_fired), .rsp_fired_id(rsp_fired_id),
      .rsp_latency(rsp_latency), .rsp_status(rsp_status),
      .rsp_new_id(rsp_new_id), .rsp_task_count(rsp_task_count)
   );

   always #10 clock = ~clock;

   // Shadow task table, kept in dispatch order exactly like the block's.
   logic [15:0] sh_id [Slots];
   logic [31:0] sh_period [Slots];
   logic [31:0] sh_last [Slots];
   logic sh_en [Slots];
   logic [2:0] sh_lvl [Slots];
   int unsigned sh_count = 0;
   logic [15:0] sh_next_id = '0;
   logic [31:0] sh_comp = '0;

   req_beat_t pending_reqs[$];     // beats waiting for the driver
   rsp_beat_t expected_rsps[$];    // predicted response beats, oldest first

   int unsigned mismatches = 0;
   int unsigned rsp_seen = 0;
   int unsigned fires_seen = 0;
   int unsigned full_seen = 0;
   int unsigned notfound_seen = 0;
   bit idle_off = 1'b0;          // last part of run: no gaps on either side
   int unsigned hold_cycles = 0; // long receiver hold-off, counted down below

   function automatic int find_task(logic [15:0] id);
      for (int i = 0; i < sh_count; i++)
         if (sh_id[i] == id) return i;
      return -1;
   endfunction

   function automatic logic [2:0] clamp_lvl(logic [7:0] p);
      return (p > TopLvl) ? 3'(TopLvl) : p[2:0];
   endfunction

   // Makes room after the last entry at level <= lvl, returns its slot.
   function automatic int open_task_slot(logic [2:0] lvl);
      int pos;
      pos = 0;
      for (int i = 0; i < sh_count; i++)
         if (sh_lvl[i] <= lvl) pos = i + 1;
      for (int i = sh_count; i > pos; i--) begin
         sh_id[i] = sh_id[i-1];
         sh_period[i] = sh_period[i-1];
         sh_last[i] = sh_last[i-1];
         sh_en[i] = sh_en[i-1];
         sh_lvl[i] = sh_lvl[i-1];
      end
      sh_count++;
      sh_lvl[pos] = lvl;
      return pos;
   endfunction

   function automatic void drop_task_slot(int pos);
      if (17'(sh_next_id) == 17'(sh_id[pos]) + 17'd1) sh_next_id = sh_id[pos];
      for (int i = pos; i + 1 < sh_count; i++) begin
         sh_id[i] = sh_id[i+1];
         sh_period[i] = sh_period[i+1];
         sh_last[i] = sh_last[i+1];
         sh_en[i] = sh_en[i+1];
         sh_lvl[i] = sh_lvl[i+1];
      end
      sh_count--;
   endfunction

   // Applies one request to the shadow table and returns the expected beat.
   function automatic rsp_beat_t dispatch_outcome(req_beat_t r);
      rsp_beat_t o;
      logic [31:0] per, due, lat;
      logic [15:0] cand, sid;
      logic [31:0] sper, slr;
      logic sen;
      int k, pos;
      bit hit;
      o = '{fired: 1'b0, fired_id: '0, latency: '0, status: StatusOk,
            new_id: NoId, task_count: '0};
      per = (r.period == 0) ? 32'd1 : r.period;
      k = -1;
      if (r.act inside {ACT_DELETE, ACT_STATE, ACT_PERIOD, ACT_DELAY, ACT_PRIO}) begin
         k = find_task(r.task_id);
         if (k < 0) o.status = StatusNotFound;
      end
      case (r.act)
         ACT_TICK: begin
            for (int i = 0; i < sh_count; i++) begin
               due = sh_last[i] + sh_period[i];
               if (sh_en[i] && r.now >= due) begin
                  lat = r.now - due;
                  sh_last[i] = (lat <= sh_comp) ? due : r.now;
                  o.fired = 1'b1;
                  o.fired_id = sh_id[i];
                  o.latency = lat;
                  break;
               end
            end
         end
         ACT_CREATE: begin
            if (sh_count >= Slots) begin
               o.status = StatusFull;
            end else begin
               cand = sh_next_id;
               hit = 1'b1;
               while (hit) begin
                  hit = 1'b0;
                  if (cand == NoId) cand = '0;
                  for (int i = 0; i < sh_count; i++)
                     if (sh_id[i] == cand) begin
                        cand = cand + 16'd1;
                        hit = 1'b1;
                        break;
                     end
               end
               pos = open_task_slot(clamp_lvl(r.prio));
               sh_id[pos] = cand;
               sh_period[pos] = per;
               sh_last[pos] = r.now - per;
               sh_en[pos] = (r.mode != ModeDisable);
               sh_next_id = cand + 16'd1;
               o.new_id = cand;
            end
         end
         default: begin
            if (k >= 0) begin
               case (r.act)
                  ACT_DELETE: drop_task_slot(k);
                  ACT_STATE: begin
                     if (r.mode == ModeToggle) sh_en[k] = ~sh_en[k];
                     else sh_en[k] = (r.mode != ModeDisable);
                     if (sh_en[k]) sh_last[k] = r.now - sh_period[k];
                  end
                  ACT_PERIOD: begin
                     sh_period[k] = per;
                     sh_last[k] = r.now - per;
                  end
                  ACT_DELAY: begin
                     if (r.from_now) sh_last[k] = r.now + r.dly;
                     else sh_last[k] = sh_last[k] + r.dly;
                  end
                  ACT_PRIO: begin
                     sid = sh_id[k];
                     sper = sh_period[k];
                     slr = sh_last[k];
                     sen = sh_en[k];
                     drop_task_slot(k);
                     pos = open_task_slot(clamp_lvl(r.prio));
                     sh_id[pos] = sid;
                     sh_period[pos] = sper;
                     sh_last[pos] = slr;
                     sh_en[pos] = sen;
                  end
                  default: ;
               endcase
            end
         end
      endcase
      o.task_count = 5'(sh_count);
      return o;
   endfunction

   // Driver: one beat from the queue at a time, random gaps between beats.
   int unsigned drv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready && !idle_off && $urandom_range(0, 3) == 0)
            drv_gap = $urandom_range(1, 3);
         else if (drv_gap > 0 && !req_valid)
            drv_gap--;
         // valid that stays up is never dropped: only load when free or just taken
         if ((!req_valid || req_ready) && drv_gap == 0 && pending_reqs.size() > 0) begin
            req_beat_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(dispatch_outcome(r));
            req_action <= r.act;
            req_now <= r.now;
            req_task_id <= r.task_id;
            req_priority_req <= r.prio;
            req_period <= r.period;
            req_enable_mode <= r.mode;
            req_delay_ticks <= r.dly;
            req_from_now <= r.from_now;
            req_valid <= 1'b1;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted response beat with the oldest prediction.
   int unsigned rcv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_beat_t e;
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: response beat with nothing expected", $realtime);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_fired !== e.fired || rsp_fired_id !== e.fired_id ||
                   rsp_latency !== e.latency || rsp_status !== e.status ||
                   rsp_new_id !== e.new_id || rsp_task_count !== e.task_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp f=%0d id=%0d lat=%0d st=%0d nid=%0d cnt=%0d",
                              $realtime, e.fired, e.fired_id, e.latency, e.status,
                              e.new_id, e.task_count,
                              " got f=%0d id=%0d lat=%0d st=%0d nid=%0d cnt=%0d",
                              rsp_fired, rsp_fired_id, rsp_latency, rsp_status,
                              rsp_new_id, rsp_task_count);
               end
               if (e.fired) fires_seen++;
               if (e.status == StatusFull) full_seen++;
               if (e.status == StatusNotFound) notfound_seen++;
            end
         end
         // receiver stalls: long hold-off when asked, else short random bursts
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 5) == 0) begin
            rcv_gap = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Picks an id that is usually live in the table, sometimes a stranger.
   function automatic logic [15:0] pick_id();
      if (sh_count > 0 && $urandom_range(0, 9) != 0)
         return sh_id[$urandom_range(0, sh_count - 1)];
      return 16'($urandom_range(0, 65534));
   endfunction

   logic [31:0] clk_now = 32'd1000;

   // Random well-formed request; time mostly creeps forward so tasks fall due.
   function automatic req_beat_t rand_beat();
      req_beat_t r;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) clk_now = $urandom;
      else clk_now = clk_now + $urandom_range(0, 40);
      r.now = clk_now;
      r.task_id = pick_id();
      r.prio = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      r.period = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60);
      r.mode = 2'($urandom_range(0, 3));
      r.dly = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 80);
      r.from_now = 1'($urandom);
      if (sel < 40) r.act = ACT_TICK;
      else if (sel < 58) r.act = ACT_CREATE;
      else if (sel < 66) r.act = ACT_DELETE;
      else if (sel < 76) r.act = ACT_STATE;
      else if (sel < 83) r.act = ACT_PERIOD;
      else if (sel < 91) r.act = ACT_DELAY;
      else if (sel < 98) r.act = ACT_PRIO;
      else r.act = ACT_NONE;
      return r;
   endfunction

   function automatic req_beat_t mk(action_type a, logic [31:0] now, logic [15:0] id,
                                    logic [7:0] p, logic [31:0] per, logic [1:0] m,
                                    logic [31:0] d, logic fn);
      req_beat_t r;
      r = '{act: a, now: now, task_id: id, prio: p, period: per, mode: m,
            dly: d, from_now: fn};
      return r;
   endfunction

   // Wait until the block has answered everything, then let it settle.
   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_comp(logic [31:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      sh_comp = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_comp(32'd0);

      // Directed: extremes, every action, the corner cases.
      pending_reqs.push_back(mk(ACT_TICK, 32'd0, 16'd0, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_DELETE, 32'd5, 16'd65534, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'd0, 2'd3,
                                32'hFFFF_FFFF, 1'b1));
      pending_reqs.push_back(mk(ACT_CREATE, 32'd10, 16'd0, 8'd0, 32'hFFFF_FFFF, 2'd2,
                                32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_CREATE, 32'd10, 16'd0, 8'd3, 32'd5, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_TICK, 32'd10, 16'd0, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_STATE, 32'd20, 16'd2, 8'd0, 32'd0, 2'd3, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_STATE, 32'd21, 16'd2, 8'd0, 32'd0, 2'd2, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_STATE, 32'd22, 16'd2, 8'd0, 32'd0, 2'd2, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_TICK, 32'd40, 16'd0, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_PERIOD, 32'd50, 16'd2, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_DELAY, 32'd50, 16'd2, 8'd0, 32'd0, 2'd0,
                                32'hFFFF_FFFF, 1'b0));
      pending_reqs.push_back(mk(ACT_DELAY, 32'd50, 16'd2, 8'd0, 32'd0, 2'd0, 32'd7, 1'b1));
      pending_reqs.push_back(mk(ACT_PRIO, 32'd50, 16'd2, 8'hFF, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_PRIO, 32'd50, 16'd0, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      // deleting the newest id steps the free id back
      pending_reqs.push_back(mk(ACT_DELETE, 32'd50, 16'd2, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_CREATE, 32'd50, 16'd0, 8'd1, 32'd1, 2'd1, 32'd0, 1'b0));
      pending_reqs.push_back(mk(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                                2'd3, 32'hFFFF_FFFF, 1'b1));
      pending_reqs.push_back(mk(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 8'd0, 32'd0, 2'd0, 32'd0, 1'b0));
      // fill the table past full
      for (int i = 0; i < 16; i++)
         pending_reqs.push_back(mk(ACT_CREATE, 32'd60, 16'd0, 8'(i % 9), 32'd3, 2'd1,
                                   32'd0, 1'b0));
      drain();

      // Random phases across comp_range settings, table refilled as it goes.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_comp(32'd0);
            1: write_comp(32'hFFFF_FFFF);
            2: write_comp(32'd5);
            3: write_comp($urandom_range(0, 30));
            default: write_comp($urandom);
         endcase
         if (ph == 4) idle_off = 1'b1;
         for (int n = 0; n < 220; n++) begin
            req_beat_t r;
            r = rand_beat();
            // occasionally reach for the full table or an empty one
            if (ph == 2 && n < 20) r.act = ACT_CREATE;
            if (ph == 3 && n < 18) r.act = ACT_DELETE;
            pending_reqs.push_back(r);
         end
         if (ph == 1) hold_cycles = 400; // block fills up and stalls its input
         drain();
      end

      $display("Covered %0d responses: %0d dispatches, %0d table-full, %0d unknown-id.",
               rsp_seen, fires_seen, full_seen, notfound_seen);
      $display("comp_range swept over zero, all-ones, small and random values.");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses never came", mismatches,
                  expected_rsps.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legitimate run.
   initial begin
      #40ms;
      $display("Timeout waiting for the block");
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
